// ===== hw/rtl/rtp_pkg.sv =====
// Shared types and constants for the remote tape reply parser.
// No dependencies; imported by rtp_cfg_if and the top level.
package rtp_pkg;

	localparam logic [7:0] CHAR_A     = 8'h41;
	localparam logic [7:0] CHAR_E     = 8'h45;
	localparam logic [7:0] CHAR_F     = 8'h46;
	localparam logic [7:0] CHAR_NL    = 8'h0A;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_CODE_LINE_LIMIT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_LINE_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUIET_PROBE        = 2'd2;

	localparam logic [7:0]  CODE_LINE_LIMIT_RST    = 8'd29;
	localparam logic [15:0] MESSAGE_LINE_LIMIT_RST = 16'd1023;

	typedef enum logic [2:0] {
		ST_ACK    = 3'd0,
		ST_ERR    = 3'd1,
		ST_FATAL  = 3'd2,
		ST_BOTCH  = 3'd3,
		ST_LONG   = 3'd4,
		ST_RXFAIL = 3'd5
	} status_t;

endpackage

// ===== hw/rtl/rtp_if.sv =====
// Valid/ready channel interfaces of the remote tape reply parser:
// received bytes, parsed replies and register writes. Depends on rtp_pkg.
interface rtp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       rx_fail;

	modport source (output valid, rx_byte, rx_fail, input ready);
	modport sink (input valid, rx_byte, rx_fail, output ready);
endinterface

interface rtp_reply_if;
	logic               valid;
	logic               ready;
	logic [2:0]         reply_status;
	logic signed [31:0] reply_value;
	logic               drop_connection;
	logic               mark_closed;

	modport source (output valid, reply_status, reply_value, drop_connection, mark_closed,
		input ready);
	modport sink (input valid, reply_status, reply_value, drop_connection, mark_closed,
		output ready);
endinterface

interface rtp_cfg_if;
	import rtp_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [15:0]          data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/remote_tape_reply_parser_top.sv =====
// Remote tape reply parser: input register, one pass of parse logic, result register.
// A byte that ends a reply goes through the input register, then its result into the result register.
// Throughput: one byte per cycle, unless a finished result must wait for a full result register.
// The result register holds a waiting result while the next byte is taken.
// Reset (arst_n low, asynchronous): parser waits for a code character, number
// state and counts clear, registers return to 29 / 1023 / not quiet.
module remote_tape_reply_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	rtp_rx_if.sink      rx,
	rtp_reply_if.source reply,
	rtp_cfg_if.sink     cfg
);
	import rtp_pkg::*;

	typedef enum logic [1:0] {
		PH_WAIT = 2'd0,
		PH_CODE = 2'd1,
		PH_MSG  = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		NUM_SKIP   = 2'd0,
		NUM_DIGITS = 2'd1,
		NUM_DONE   = 2'd2
	} num_phase_t;

	// configuration
	logic [7:0]  code_limit_q;
	logic [15:0] msg_limit_q;
	logic        quiet_q;

	// parse state
	phase_t      phase_q;
	logic [7:0]  kind_q;
	logic [15:0] cnt_q;
	num_phase_t  nph_q;
	logic        neg_q;
	logic [31:0] acc_q;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       fail_s1;

	// result stage
	logic        valid_s2;
	status_t     status_s2;
	logic [31:0] value_s2;
	logic        drop_s2;
	logic        closed_s2;

	phase_t      nxt_phase;
	logic [7:0]  nxt_kind;
	logic [15:0] nxt_cnt;
	num_phase_t  nxt_nph;
	logic        nxt_neg;
	logic [31:0] nxt_acc;
	logic        emit;
	status_t     res_status;
	logic [31:0] res_value;
	logic        res_drop;
	logic        res_closed;

	logic [15:0] cnt_inc;
	logic [31:0] acc_next_digit;
	logic        is_nl, is_digit, is_space, is_sign;
	logic        out_free, s1_fire;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_limit_q <= CODE_LINE_LIMIT_RST;
			msg_limit_q  <= MESSAGE_LINE_LIMIT_RST;
			quiet_q      <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_CODE_LINE_LIMIT:    code_limit_q <= cfg.data[7:0];
				REG_MESSAGE_LINE_LIMIT: msg_limit_q  <= cfg.data;
				REG_QUIET_PROBE:        quiet_q      <= cfg.data[0];
				default:                ;
			endcase
		end
	end

	assign cnt_inc  = (cnt_q == 16'hFFFF) ? cnt_q : cnt_q + 16'd1;
	assign is_nl    = (byte_s1 == CHAR_NL);
	assign is_digit = (byte_s1 >= CHAR_ZERO) && (byte_s1 <= CHAR_NINE);
	assign is_space = (byte_s1 == CHAR_SPACE) || ((byte_s1 >= CHAR_TAB) && (byte_s1 <= CHAR_CR));
	assign is_sign  = (byte_s1 == CHAR_PLUS) || (byte_s1 == CHAR_MINUS);
	// times ten as two shifts and an add
	assign acc_next_digit = (acc_q << 3) + (acc_q << 1) + {28'd0, byte_s1[3:0]};

	always_comb begin
		nxt_phase  = phase_q;
		nxt_kind   = kind_q;
		nxt_cnt    = cnt_q;
		nxt_nph    = nph_q;
		nxt_neg    = neg_q;
		nxt_acc    = acc_q;
		emit       = 1'b0;
		res_status = ST_ACK;
		res_value  = '1;
		res_drop   = 1'b0;
		res_closed = 1'b0;

		if (fail_s1) begin
			emit       = 1'b1;
			res_status = ST_RXFAIL;
			res_drop   = !quiet_q;
		end else if (phase_q == PH_MSG) begin
			nxt_cnt = cnt_inc;
			if (is_nl) begin
				emit = 1'b1;
				if (kind_q == CHAR_F) begin
					res_status = ST_FATAL;
					res_closed = 1'b1;
				end else begin
					res_status = ST_ERR;
				end
			end else if (cnt_inc >= msg_limit_q) begin
				emit       = 1'b1;
				res_status = ST_LONG;
				res_drop   = 1'b1;
			end
		end else begin
			nxt_phase = PH_CODE;
			if (phase_q != PH_CODE) begin
				// first character picks the reply kind and is not part of the number
				nxt_kind = byte_s1;
				nxt_cnt  = 16'd1;
				nxt_nph  = NUM_SKIP;
				nxt_neg  = 1'b0;
				nxt_acc  = '0;
			end else begin
				nxt_cnt = cnt_inc;
				if (!is_nl && nph_q != NUM_DONE) begin
					if (is_digit) begin
						nxt_acc = acc_next_digit;
						nxt_nph = NUM_DIGITS;
					end else if (nph_q == NUM_SKIP && is_space) begin
						nxt_nph = NUM_SKIP;
					end else if (nph_q == NUM_SKIP && is_sign) begin
						nxt_neg = (byte_s1 == CHAR_MINUS);
						nxt_nph = NUM_DIGITS;
					end else begin
						nxt_nph = NUM_DONE;
					end
				end
			end

			if (is_nl) begin
				if (nxt_kind == CHAR_A) begin
					emit       = 1'b1;
					res_status = ST_ACK;
					res_value  = nxt_neg ? (32'd0 - nxt_acc) : nxt_acc;
				end else if (nxt_kind == CHAR_E || nxt_kind == CHAR_F) begin
					nxt_phase = PH_MSG;
					nxt_cnt   = '0;
				end else begin
					emit       = 1'b1;
					res_status = ST_BOTCH;
					res_drop   = 1'b1;
				end
			end else if (nxt_cnt >= {8'd0, code_limit_q}) begin
				emit       = 1'b1;
				res_status = ST_LONG;
				res_drop   = 1'b1;
			end
		end

		// every result sends the parser back to waiting
		if (emit) begin
			nxt_phase = PH_WAIT;
			nxt_cnt   = '0;
			nxt_nph   = NUM_SKIP;
			nxt_neg   = 1'b0;
			nxt_acc   = '0;
		end
	end

	assign out_free = !valid_s2 || reply.ready;
	assign s1_fire  = valid_s1 && (!emit || out_free);
	assign rx.ready = !valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			phase_q  <= PH_WAIT;
			kind_q   <= '0;
			cnt_q    <= '0;
			nph_q    <= NUM_SKIP;
			neg_q    <= 1'b0;
			acc_q    <= '0;
		end else begin
			if (rx.valid && rx.ready) begin
				valid_s1 <= 1'b1;
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end

			if (s1_fire && emit) begin
				valid_s2 <= 1'b1;
			end else if (reply.ready) begin
				valid_s2 <= 1'b0;
			end

			if (s1_fire) begin
				phase_q <= nxt_phase;
				kind_q  <= nxt_kind;
				cnt_q   <= nxt_cnt;
				nph_q   <= nxt_nph;
				neg_q   <= nxt_neg;
				acc_q   <= nxt_acc;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
			fail_s1 <= rx.rx_fail;
		end
		if (s1_fire && emit) begin
			status_s2 <= res_status;
			value_s2  <= res_value;
			drop_s2   <= res_drop;
			closed_s2 <= res_closed;
		end
	end

	assign reply.valid           = valid_s2;
	assign reply.reply_status    = status_s2;
	assign reply.reply_value     = value_s2;
	assign reply.drop_connection = drop_s2;
	assign reply.mark_closed     = closed_s2;

	a_value_minus_one: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && status_s2 != ST_ACK |-> value_s2 == 32'hFFFF_FFFF)
		else $error("non-ack result carries a value other than -1");

	a_closed_only_fatal: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && closed_s2 |-> status_s2 == ST_FATAL && !drop_s2)
		else $error("tape closed on a result that is not fatal");

	a_drop_on_botch_long: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (status_s2 == ST_BOTCH || status_s2 == ST_LONG) |-> drop_s2)
		else $error("botched or too long reply keeps the connection");

	a_msg_kind: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_MSG |-> kind_q == CHAR_E || kind_q == CHAR_F)
		else $error("message line taken for a reply kind other than E or F");

endmodule
